>>> rtl/hrsf_pkg.sv
`default_nettype none

package hrsf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LIMIT_W  = 15;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned NAME_IW  = 5;
    localparam int unsigned VALUE_IW = 4;

    localparam logic [LIMIT_W-1:0]  BYTE_LIMIT_RESET  = 15'd8192;
    localparam logic [COUNT_W-1:0]  BYTE_COUNT_MAX    = 16'd32768;
    localparam logic [NAME_IW-1:0]  NAME_CL_LEN       = 5'd14;
    localparam logic [NAME_IW-1:0]  NAME_TE_LEN       = 5'd17;
    localparam logic [NAME_IW-1:0]  NAME_INDEX_MAX    = 5'd31;
    localparam logic [VALUE_IW-1:0] VAL_CHUNKED_LEN   = 4'd7;
    localparam logic [VALUE_IW-1:0] VAL_IDENTITY_LEN  = 4'd8;
    localparam logic [VALUE_IW-1:0] VALUE_INDEX_MAX   = 4'd15;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SP    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_LO_M  = 8'h6D;
    localparam logic [BYTE_W-1:0] CH_LO_C  = 8'h63;
    localparam logic [BYTE_W-1:0] CH_LO_P  = 8'h70;

    typedef enum logic [2:0] {
        V_NEED_MORE = 3'd0,
        V_NOT_MCP   = 3'd1,
        V_INVALID   = 3'd2,
        V_SMUGGLING = 3'd3,
        V_MCP       = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        LP_METHOD = 3'd0,
        LP_TARGET = 3'd1,
        LP_REST   = 3'd2,
        LP_QUERY  = 3'd3,
        LP_DONE   = 3'd4
    } t_line_phase;

    typedef enum logic [3:0] {
        PS_SLASH = 4'd0,
        PS_M     = 4'd1,
        PS_C     = 4'd2,
        PS_P     = 4'd3,
        PS_MCP   = 4'd4,
        PS_SEP   = 4'd5,
        PS_SEG   = 4'd6,
        PS_NOT   = 4'd7,
        PS_INV   = 4'd8
    } t_path_state;

    typedef enum logic [1:0] {
        LV_PENDING = 2'd0,
        LV_NOT_MCP = 2'd1,
        LV_INVALID = 2'd2,
        LV_PASS    = 2'd3
    } t_line_verdict;

    typedef struct packed {
        logic active;
        logic stop;
        logic colon;
        logic lead;
        logic crhold;
        logic started;
        logic content;
    } t_scan_flags;

    typedef struct packed {
        logic cl;
        logic te;
        logic chunked;
        logic identity;
    } t_match_flags;

    typedef struct packed {
        logic                chunked;
        logic                identity;
        logic [VALUE_IW-1:0] idx;
    } t_value_scan;

    typedef struct packed {
        t_line_phase phase;
        t_path_state path;
    } t_line_scan;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic is_safe(input logic [BYTE_W-1:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                         8'h2E, 8'h5F, 8'h7E, 8'h2D};
    endfunction

    // "content-length"
    function automatic logic [BYTE_W-1:0] name_cl_char(input logic [NAME_IW-1:0] i);
        logic [BYTE_W-1:0] c;
        case (i)
            5'd0:    c = "c";
            5'd1:    c = "o";
            5'd2:    c = "n";
            5'd3:    c = "t";
            5'd4:    c = "e";
            5'd5:    c = "n";
            5'd6:    c = "t";
            5'd7:    c = "-";
            5'd8:    c = "l";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "g";
            5'd12:   c = "t";
            5'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "transfer-encoding"
    function automatic logic [BYTE_W-1:0] name_te_char(input logic [NAME_IW-1:0] i);
        logic [BYTE_W-1:0] c;
        case (i)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] val_chunked_char(input logic [VALUE_IW-1:0] i);
        logic [BYTE_W-1:0] c;
        case (i)
            4'd0:    c = "c";
            4'd1:    c = "h";
            4'd2:    c = "u";
            4'd3:    c = "n";
            4'd4:    c = "k";
            4'd5:    c = "e";
            4'd6:    c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] val_identity_char(input logic [VALUE_IW-1:0] i);
        logic [BYTE_W-1:0] c;
        case (i)
            4'd0:    c = "i";
            4'd1:    c = "d";
            4'd2:    c = "e";
            4'd3:    c = "n";
            4'd4:    c = "t";
            4'd5:    c = "i";
            4'd6:    c = "t";
            4'd7:    c = "y";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_value_scan value_step(input t_value_scan s,
                                               input logic [BYTE_W-1:0] c);
        t_value_scan       r;
        logic [BYTE_W-1:0] lc;
        r  = s;
        lc = to_lower(c);
        if (s.idx < VAL_CHUNKED_LEN && lc != val_chunked_char(s.idx)) begin
            r.chunked = 1'b0;
        end
        if (s.idx < VAL_IDENTITY_LEN && lc != val_identity_char(s.idx)) begin
            r.identity = 1'b0;
        end
        if (s.idx < VALUE_INDEX_MAX) begin
            r.idx = s.idx + 4'd1;
        end
        return r;
    endfunction

    function automatic t_path_state path_step(input t_path_state p,
                                              input logic [BYTE_W-1:0] c);
        t_path_state r;
        r = p;
        case (p)
            PS_SLASH: r = (c == CH_SLASH) ? PS_M : PS_NOT;
            PS_M:     r = (c == CH_LO_M) ? PS_C : PS_NOT;
            PS_C:     r = (c == CH_LO_C) ? PS_P : PS_NOT;
            PS_P:     r = (c == CH_LO_P) ? PS_MCP : PS_NOT;
            PS_MCP:   r = (c == CH_SLASH) ? PS_SEP : PS_NOT;
            PS_SEP:   r = is_safe(c) ? PS_SEG : PS_INV;
            PS_SEG:   r = (c == CH_SLASH) ? PS_SEP : (is_safe(c) ? PS_SEG : PS_INV);
            default:  r = p;
        endcase
        return r;
    endfunction

    function automatic t_line_scan line_char(input t_line_scan s,
                                             input logic [BYTE_W-1:0] c);
        t_line_scan r;
        r = s;
        case (s.phase)
            LP_METHOD: begin
                if (c == CH_SP) r.phase = LP_TARGET;
            end
            LP_TARGET: begin
                if (c == CH_SP) begin
                    r.phase = LP_REST;
                end else if (c == CH_QUEST) begin
                    r.phase = LP_QUERY;
                end else begin
                    r.path = path_step(s.path, c);
                end
            end
            LP_QUERY: begin
                if (c == CH_SP) r.phase = LP_REST;
            end
            default: r = s;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hrsf_in_if.sv
`default_nettype none

interface hrsf_in_if
    import hrsf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              first_of_stream;

    modport src (output valid, output data_byte, output first_of_stream, input ready);
    modport snk (input valid, input data_byte, input first_of_stream, output ready);
endinterface

`default_nettype wire

>>> rtl/hrsf_out_if.sv
`default_nettype none

interface hrsf_out_if
    import hrsf_pkg::*;
();
    logic     valid;
    logic     ready;
    t_verdict verdict;
    logic     settled;

    modport src (output valid, output verdict, output settled, input ready);
    modport snk (input valid, input verdict, input settled, output ready);
endinterface

`default_nettype wire

>>> rtl/hrsf_cfg_if.sv
`default_nettype none

interface hrsf_cfg_if
    import hrsf_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] byte_limit;

    modport src (output valid, output byte_limit, input ready);
    modport snk (input valid, input byte_limit, output ready);
endinterface

`default_nettype wire

>>> rtl/http_request_sniff_filter_unit.sv
// http request sniff filter
// classifies the opening bytes of a connection, one byte per item
// i_item: data_byte plus first_of_stream, which starts a new connection
// o_result: verdict and settled for the prefix received so far, one per item
// i_cfg: writes byte_limit; always ready, write only while the block is idle
// output: the result is registered on acceptance, valid the cycle after
// throughput: one item per cycle; the whole parse step is one combinational
//   pass from the parse state registers and the input byte to the result
// stall: while a result waits on o_result.ready the input takes one more item
//   only if that result is taken in the same cycle
// reset: synchronous on i_rst_n, clears the parse state and the output valid,
//   byte_limit returns to 8192
`default_nettype none

module http_request_sniff_filter_unit
    import hrsf_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    hrsf_in_if.snk  i_item,
    hrsf_cfg_if.snk i_cfg,
    hrsf_out_if.src o_result
);

    logic [LIMIT_W-1:0]  r_byte_limit;
    logic [COUNT_W-1:0]  r_byte_count;
    t_line_phase         r_line_phase;
    logic                r_line_cr_pending;
    t_path_state         r_path_state;
    t_line_verdict       r_line_verdict;
    logic [2:0]          r_term;
    logic                r_headers_done;
    t_scan_flags         r_scan;
    logic [NAME_IW-1:0]  r_name_index;
    logic [VALUE_IW-1:0] r_value_index;
    t_match_flags        r_match;
    logic [1:0]          r_len_count;
    logic                r_enc_seen;
    logic                r_enc_bad;
    logic                r_out_valid;
    t_verdict            r_verdict;
    logic                r_settled;

    logic [COUNT_W-1:0]  n_byte_count;
    t_line_phase         n_line_phase;
    logic                n_line_cr_pending;
    t_path_state         n_path_state;
    t_line_verdict       n_line_verdict;
    logic [2:0]          n_term;
    logic                n_headers_done;
    t_scan_flags         n_scan;
    logic [NAME_IW-1:0]  n_name_index;
    logic [VALUE_IW-1:0] n_value_index;
    t_match_flags        n_match;
    logic [1:0]          n_len_count;
    logic                n_enc_seen;
    logic                n_enc_bad;
    t_verdict            n_verdict;
    logic                n_settled;

    logic in_accept;
    logic out_free;

    assign out_free       = !r_out_valid || o_result.ready;
    assign i_item.ready   = out_free;
    assign in_accept      = i_item.valid && out_free;
    assign i_cfg.ready    = 1'b1;
    assign o_result.valid = r_out_valid;
    assign o_result.verdict = r_verdict;
    assign o_result.settled = r_settled;

    // next parse state
    always_comb begin
        logic [BYTE_W-1:0] c;
        logic              was_settled;
        logic              line_ended;
        logic              skip;
        logic              ok;
        logic              is_cl;
        logic              is_te;
        logic [BYTE_W-1:0] lc;
        t_value_scan       vs;
        t_line_scan        ls;

        c = i_item.data_byte;
        n_byte_count      = r_byte_count;
        n_line_phase      = r_line_phase;
        n_line_cr_pending = r_line_cr_pending;
        n_path_state      = r_path_state;
        n_line_verdict    = r_line_verdict;
        n_term            = r_term;
        n_headers_done    = r_headers_done;
        n_scan            = r_scan;
        n_name_index      = r_name_index;
        n_value_index     = r_value_index;
        n_match           = r_match;
        n_len_count       = r_len_count;
        n_enc_seen        = r_enc_seen;
        n_enc_bad         = r_enc_bad;
        if (i_item.first_of_stream) begin
            n_byte_count      = '0;
            n_line_phase      = LP_METHOD;
            n_line_cr_pending = 1'b0;
            n_path_state      = PS_SLASH;
            n_line_verdict    = LV_PENDING;
            n_term            = 3'd0;
            n_headers_done    = 1'b0;
            n_scan            = '0;
            n_name_index      = '0;
            n_value_index     = '0;
            n_match           = '1;
            n_len_count       = 2'd0;
            n_enc_seen        = 1'b0;
            n_enc_bad         = 1'b0;
        end
        if (n_byte_count < BYTE_COUNT_MAX) begin
            n_byte_count = n_byte_count + 16'd1;
        end

        was_settled = n_line_verdict == LV_NOT_MCP || n_line_verdict == LV_INVALID ||
                      (n_line_verdict == LV_PASS && n_headers_done);
        line_ended = 1'b0;
        skip  = 1'b0;
        ok    = 1'b0;
        is_cl = 1'b0;
        is_te = 1'b0;
        lc    = to_lower(c);
        vs    = '{chunked: n_match.chunked, identity: n_match.identity, idx: n_value_index};
        ls    = '{phase: n_line_phase, path: n_path_state};

        if (!was_settled) begin
            // header scan
            if (!n_scan.active) begin
                if (c == CH_LF) begin
                    n_scan        = '0;
                    n_scan.active = 1'b1;
                    n_name_index  = '0;
                    n_value_index = '0;
                    n_match       = '1;
                end
            end else if (!n_scan.stop) begin
                if (c == CH_LF) begin
                    if (!n_scan.content) begin
                        n_scan.stop = 1'b1;
                    end else if (n_scan.colon && n_match.te) begin
                        ok = (n_match.chunked && n_value_index == VAL_CHUNKED_LEN) ||
                             (n_match.identity && n_value_index == VAL_IDENTITY_LEN);
                        if (!ok) n_enc_bad = 1'b1;
                    end
                    n_scan.colon   = 1'b0;
                    n_scan.lead    = 1'b0;
                    n_scan.crhold  = 1'b0;
                    n_scan.started = 1'b0;
                    n_scan.content = 1'b0;
                    n_name_index   = '0;
                    n_value_index  = '0;
                    n_match        = '1;
                end else begin
                    if (!n_scan.started && c == CH_CR) begin
                        n_scan.started = 1'b1;
                    end else begin
                        n_scan.started = 1'b1;
                        n_scan.content = 1'b1;
                    end
                    if (!n_scan.colon) begin
                        if (c == CH_COLON) begin
                            is_cl = n_match.cl && n_name_index == NAME_CL_LEN;
                            is_te = n_match.te && n_name_index == NAME_TE_LEN;
                            n_scan.colon  = 1'b1;
                            n_scan.lead   = 1'b1;
                            n_value_index = '0;
                            if (is_cl && n_len_count < 2'd2) begin
                                n_len_count = n_len_count + 2'd1;
                            end
                            if (is_te) begin
                                n_enc_seen = 1'b1;
                                n_match    = '{cl: 1'b0, te: 1'b1, chunked: 1'b1,
                                               identity: 1'b1};
                            end else begin
                                n_match = '0;
                            end
                        end else begin
                            if (n_name_index < NAME_CL_LEN && lc != name_cl_char(n_name_index)) begin
                                n_match.cl = 1'b0;
                            end
                            if (n_name_index < NAME_TE_LEN && lc != name_te_char(n_name_index)) begin
                                n_match.te = 1'b0;
                            end
                            if (n_name_index < NAME_INDEX_MAX) begin
                                n_name_index = n_name_index + 5'd1;
                            end
                        end
                    end else if (n_match.te) begin
                        if (n_scan.lead) begin
                            if (c == CH_SP || c == CH_TAB) begin
                                skip = 1'b1;
                            end else begin
                                n_scan.lead = 1'b0;
                            end
                        end
                        if (!skip) begin
                            if (n_scan.crhold) begin
                                n_scan.crhold = 1'b0;
                                vs = value_step(vs, CH_CR);
                            end
                            if (c == CH_CR) begin
                                n_scan.crhold = 1'b1;
                            end else begin
                                vs = value_step(vs, c);
                            end
                            n_match.chunked  = vs.chunked;
                            n_match.identity = vs.identity;
                            n_value_index    = vs.idx;
                        end
                    end
                end
            end

            // request line
            if (n_line_phase != LP_DONE) begin
                if (n_line_cr_pending) begin
                    n_line_cr_pending = 1'b0;
                    if (c == CH_LF) begin
                        line_ended = 1'b1;
                    end else begin
                        ls = line_char(ls, CH_CR);
                    end
                end
                if (line_ended) begin
                    if (ls.phase != LP_REST) begin
                        n_line_verdict = LV_NOT_MCP;
                    end else if (ls.path == PS_MCP || ls.path == PS_SEP ||
                                 ls.path == PS_SEG) begin
                        n_line_verdict = LV_PASS;
                    end else if (ls.path == PS_INV) begin
                        n_line_verdict = LV_INVALID;
                    end else begin
                        n_line_verdict = LV_NOT_MCP;
                    end
                    ls.phase = LP_DONE;
                end else if (c == CH_CR) begin
                    n_line_cr_pending = 1'b1;
                end else begin
                    ls = line_char(ls, c);
                end
                n_line_phase = ls.phase;
                n_path_state = ls.path;
            end

            // header terminator
            if (c == CH_CR) begin
                n_term = (n_term == 3'd2) ? 3'd3 : 3'd1;
            end else if (c == CH_LF) begin
                n_term = (n_term == 3'd1) ? 3'd2 : ((n_term == 3'd3) ? 3'd4 : 3'd0);
            end else begin
                n_term = 3'd0;
            end
            if (n_term == 3'd4) n_headers_done = 1'b1;
        end
    end

    // result for the updated state
    always_comb begin
        logic smug;
        smug = n_len_count > 2'd1 || (n_enc_seen && n_len_count > 2'd0) ||
               (n_enc_seen && n_enc_bad);
        n_settled = 1'b0;
        case (n_line_verdict)
            LV_PENDING: begin
                n_verdict = (n_byte_count > {1'b0, r_byte_limit}) ? V_NOT_MCP : V_NEED_MORE;
            end
            LV_NOT_MCP: begin
                n_verdict = V_NOT_MCP;
                n_settled = 1'b1;
            end
            LV_INVALID: begin
                n_verdict = V_INVALID;
                n_settled = 1'b1;
            end
            LV_PASS: begin
                if (n_headers_done) begin
                    n_verdict = smug ? V_SMUGGLING : V_MCP;
                    n_settled = 1'b1;
                end else begin
                    n_verdict = (n_byte_count < {1'b0, r_byte_limit}) ? V_NEED_MORE : V_MCP;
                end
            end
            default: begin
                n_verdict = V_NEED_MORE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_limit      <= BYTE_LIMIT_RESET;
            r_byte_count      <= '0;
            r_line_phase      <= LP_METHOD;
            r_line_cr_pending <= 1'b0;
            r_path_state      <= PS_SLASH;
            r_line_verdict    <= LV_PENDING;
            r_term            <= 3'd0;
            r_headers_done    <= 1'b0;
            r_scan            <= '0;
            r_name_index      <= '0;
            r_value_index     <= '0;
            r_match           <= '1;
            r_len_count       <= 2'd0;
            r_enc_seen        <= 1'b0;
            r_enc_bad         <= 1'b0;
            r_out_valid       <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_byte_limit <= i_cfg.byte_limit;
            end
            if (in_accept) begin
                r_byte_count      <= n_byte_count;
                r_line_phase      <= n_line_phase;
                r_line_cr_pending <= n_line_cr_pending;
                r_path_state      <= n_path_state;
                r_line_verdict    <= n_line_verdict;
                r_term            <= n_term;
                r_headers_done    <= n_headers_done;
                r_scan            <= n_scan;
                r_name_index      <= n_name_index;
                r_value_index     <= n_value_index;
                r_match           <= n_match;
                r_len_count       <= n_len_count;
                r_enc_seen        <= n_enc_seen;
                r_enc_bad         <= n_enc_bad;
                r_out_valid       <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_verdict <= n_verdict;
            r_settled <= n_settled;
        end
    end

`ifndef SYNTHESIS
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_result.valid)
        else $error("accepted item produced no result");

    a_headers_need_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_headers_done |-> r_line_phase == LP_DONE)
        else $error("header end seen before request line end");

    a_line_verdict_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_line_verdict != LV_PENDING && !(in_accept && i_item.first_of_stream))
        |=> $stable(r_line_verdict))
        else $error("line verdict changed without a new connection");

    a_settled_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_line_verdict == LV_NOT_MCP && !i_item.first_of_stream)
        |=> (o_result.settled && o_result.verdict == V_NOT_MCP))
        else $error("settled not-mcp verdict did not hold");
`endif

endmodule

`default_nettype wire

>>> verif/tb_http_request_sniff_filter_unit.sv
`default_nettype none

module tb_http_request_sniff_filter_unit;
    import hrsf_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int unsigned COUNT_SAT   = 32768;
    localparam int          HOLD_CYCLES = 90;

    class verdict_scoreboard;
        typedef struct {
            t_verdict verdict;
            bit       settled;
        } t_expected;

        t_expected          verdict_q[$];
        logic [LIMIT_W-1:0] byte_limit;
        int unsigned        byte_count;
        t_line_phase        phase;
        bit                 line_cr;
        t_path_state        path;
        t_line_verdict      line_v;
        int unsigned        term_state;
        bit                 hdr_done;
        bit                 sc_active, sc_stop, sc_colon, sc_lead;
        bit                 sc_crhold, sc_started, sc_content;
        int unsigned        name_idx;
        int unsigned        value_idx;
        bit                 m_cl, m_te, m_chunked, m_identity;
        int unsigned        length_hdrs;
        bit                 enc_seen;
        bit                 enc_bad;
        int                 errors;
        string              cl_name      = "content-length";
        string              te_name      = "transfer-encoding";
        string              chunked_word = "chunked";
        string              identity_word = "identity";

        function new();
            byte_limit = BYTE_LIMIT_RESET;
            errors     = 0;
            restart_parse();
        endfunction

        function void restart_parse();
            byte_count  = 0;
            phase       = LP_METHOD;
            line_cr     = 1'b0;
            path        = PS_SLASH;
            line_v      = LV_PENDING;
            term_state  = 0;
            hdr_done    = 1'b0;
            sc_active   = 1'b0;
            sc_stop     = 1'b0;
            header_line_reset();
            length_hdrs = 0;
            enc_seen    = 1'b0;
            enc_bad     = 1'b0;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            byte_limit = value;
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        endfunction

        function bit safe_char(logic [7:0] c);
            return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A) || c == 8'h2E || c == 8'h5F ||
                   c == 8'h7E || c == 8'h2D;
        endfunction

        function void path_advance(logic [7:0] c);
            case (path)
                PS_SLASH: path = (c == CH_SLASH) ? PS_M : PS_NOT;
                PS_M:     path = (c == CH_LO_M) ? PS_C : PS_NOT;
                PS_C:     path = (c == CH_LO_C) ? PS_P : PS_NOT;
                PS_P:     path = (c == CH_LO_P) ? PS_MCP : PS_NOT;
                PS_MCP:   path = (c == CH_SLASH) ? PS_SEP : PS_NOT;
                PS_SEP:   path = safe_char(c) ? PS_SEG : PS_INV;
                PS_SEG: begin
                    if (c == CH_SLASH) path = PS_SEP;
                    else if (!safe_char(c)) path = PS_INV;
                end
                default: ;
            endcase
        endfunction

        function void line_char(logic [7:0] c);
            case (phase)
                LP_METHOD: begin
                    if (c == CH_SP) phase = LP_TARGET;
                end
                LP_TARGET: begin
                    if (c == CH_SP) phase = LP_REST;
                    else if (c == CH_QUEST) phase = LP_QUERY;
                    else path_advance(c);
                end
                LP_QUERY: begin
                    if (c == CH_SP) phase = LP_REST;
                end
                default: ;
            endcase
        endfunction

        function void line_close();
            if (phase != LP_REST) line_v = LV_NOT_MCP;
            else if (path == PS_MCP || path == PS_SEP || path == PS_SEG) line_v = LV_PASS;
            else if (path == PS_INV) line_v = LV_INVALID;
            else line_v = LV_NOT_MCP;
            phase = LP_DONE;
        endfunction

        function void line_byte(logic [7:0] c);
            if (phase == LP_DONE) return;
            if (line_cr) begin
                line_cr = 1'b0;
                if (c == CH_LF) begin
                    line_close();
                    return;
                end
                line_char(CH_CR);
            end
            if (c == CH_CR) line_cr = 1'b1;
            else line_char(c);
        endfunction

        function void header_line_reset();
            sc_colon   = 1'b0;
            sc_lead    = 1'b0;
            sc_crhold  = 1'b0;
            sc_started = 1'b0;
            sc_content = 1'b0;
            name_idx   = 0;
            value_idx  = 0;
            m_cl       = 1'b1;
            m_te       = 1'b1;
            m_chunked  = 1'b1;
            m_identity = 1'b1;
        endfunction

        function void value_char(logic [7:0] c);
            logic [7:0] lc;
            lc = lower(c);
            if (value_idx < 7 && lc != chunked_word[value_idx]) m_chunked = 1'b0;
            if (value_idx < 8 && lc != identity_word[value_idx]) m_identity = 1'b0;
            if (value_idx < 15) value_idx++;
        endfunction

        function void header_byte(logic [7:0] c);
            logic [7:0] lc;
            bit         is_cl;
            bit         is_te;
            if (!sc_active) begin
                if (c == CH_LF) begin
                    sc_active = 1'b1;
                    header_line_reset();
                end
                return;
            end
            if (sc_stop) return;
            if (c == CH_LF) begin
                if (!sc_content) begin
                    sc_stop = 1'b1;
                end else if (sc_colon && m_te) begin
                    if (!((m_chunked && value_idx == 7) || (m_identity && value_idx == 8)))
                        enc_bad = 1'b1;
                end
                header_line_reset();
                return;
            end
            if (!sc_started && c == CH_CR) begin
                sc_started = 1'b1;
            end else begin
                sc_started = 1'b1;
                sc_content = 1'b1;
            end
            if (!sc_colon) begin
                if (c == CH_COLON) begin
                    is_cl     = m_cl && name_idx == 14;
                    is_te     = m_te && name_idx == 17;
                    sc_colon  = 1'b1;
                    sc_lead   = 1'b1;
                    value_idx = 0;
                    if (is_cl && length_hdrs < 2) length_hdrs++;
                    m_cl       = 1'b0;
                    m_te       = is_te;
                    m_chunked  = is_te;
                    m_identity = is_te;
                    if (is_te) enc_seen = 1'b1;
                    return;
                end
                lc = lower(c);
                if (name_idx < 14 && lc != cl_name[name_idx]) m_cl = 1'b0;
                if (name_idx < 17 && lc != te_name[name_idx]) m_te = 1'b0;
                if (name_idx < 31) name_idx++;
                return;
            end
            if (!m_te) return;
            if (sc_lead) begin
                if (c == CH_SP || c == CH_TAB) return;
                sc_lead = 1'b0;
            end
            if (sc_crhold) begin
                sc_crhold = 1'b0;
                value_char(CH_CR);
            end
            if (c == CH_CR) sc_crhold = 1'b1;
            else value_char(c);
        endfunction

        function void term_byte(logic [7:0] c);
            if (c == CH_CR) term_state = (term_state == 2) ? 3 : 1;
            else if (c == CH_LF) term_state = (term_state == 1) ? 2 : ((term_state == 3) ? 4 : 0);
            else term_state = 0;
            if (term_state == 4) hdr_done = 1'b1;
        endfunction

        function bit settled_now();
            return line_v == LV_NOT_MCP || line_v == LV_INVALID ||
                   (line_v == LV_PASS && hdr_done);
        endfunction

        function void note_byte(logic [7:0] c, bit first);
            t_expected e;
            if (first) restart_parse();
            if (byte_count < COUNT_SAT) byte_count++;
            if (!settled_now()) begin
                header_byte(c);
                line_byte(c);
                term_byte(c);
            end
            e.settled = 1'b0;
            case (line_v)
                LV_PENDING: e.verdict = (byte_count > byte_limit) ? V_NOT_MCP : V_NEED_MORE;
                LV_NOT_MCP: begin
                    e.verdict = V_NOT_MCP;
                    e.settled = 1'b1;
                end
                LV_INVALID: begin
                    e.verdict = V_INVALID;
                    e.settled = 1'b1;
                end
                default: begin
                    if (hdr_done) begin
                        e.verdict = (length_hdrs > 1 || (enc_seen && (length_hdrs > 0 || enc_bad)))
                                    ? V_SMUGGLING : V_MCP;
                        e.settled = 1'b1;
                    end else begin
                        e.verdict = (byte_count < byte_limit) ? V_NEED_MORE : V_MCP;
                    end
                end
            endcase
            verdict_q.insert(verdict_q.size(), e);
        endfunction

        function void check_verdict(t_verdict v, logic s);
            t_expected e;
            if (verdict_q.size() == 0) begin
                $error("verdict result with no item outstanding: actual %0d", v);
                errors++;
                return;
            end
            e = verdict_q.pop_front();
            if (v !== e.verdict) begin
                $error("verdict mismatch: expected %0d, actual %0d", e.verdict, v);
                errors++;
            end
            if (s !== e.settled) begin
                $error("settled mismatch: expected %0d, actual %0d", e.settled, s);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    hrsf_in_if  item_if();
    hrsf_cfg_if cfg_if();
    hrsf_out_if res_if();

    http_request_sniff_filter_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    verdict_scoreboard sb = new();
    logic [7:0]        stream_q[$];
    int                tx_idle_pct;
    int                rx_idle_pct;
    int                stall_requests;
    int                items_sent;
    string             safe_set   =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789._~-";
    string             unsafe_set = "!#$%&*()+=,;:<>[]{}|@^";

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random back-pressure plus long holds on request
    initial begin
        int hold_left;
        int stall_served;
        hold_left    = 0;
        stall_served = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                sb.check_verdict(res_if.verdict, res_if.settled);
            if (stall_served < stall_requests) begin
                stall_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [7:0] pick_safe();
        return safe_set[$urandom_range(safe_set.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_unsafe();
        return unsafe_set[$urandom_range(unsafe_set.len() - 1)];
    endfunction

    function automatic void add_byte(input logic [7:0] b);
        stream_q.insert(stream_q.size(), b);
    endfunction

    function automatic void add_text(input string s, input bit mix);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++) begin
            ch = s[i];
            if (mix && ch >= 8'h61 && ch <= 8'h7A && $urandom_range(1) == 1) ch = ch - 8'h20;
            add_byte(ch);
        end
    endfunction

    function automatic void add_crlf();
        add_byte(CH_CR);
        add_byte(CH_LF);
    endfunction

    function automatic void add_lead();
        case ($urandom_range(3))
            0: ;
            1: add_byte(CH_SP);
            2: add_byte(CH_TAB);
            default: begin
                add_byte(CH_SP);
                add_byte(CH_TAB);
                add_byte(CH_SP);
            end
        endcase
    endfunction

    function automatic void add_segments(input bit spoil);
        int nseg;
        int bad_at;
        nseg   = $urandom_range(1, 3);
        bad_at = spoil ? $urandom_range(0, nseg - 1) : -1;
        for (int s = 0; s < nseg; s++) begin
            if (s > 0) add_byte(CH_SLASH);
            if (s == bad_at) add_byte(pick_unsafe());
            repeat ($urandom_range(1, 4)) add_byte(pick_safe());
        end
    endfunction

    function automatic void add_target();
        case ($urandom_range(11))
            0, 1: add_text("/mcp", 0);
            2: add_text("/mcp/", 0);
            3, 4: begin
                add_text("/mcp/", 0);
                add_segments(0);
            end
            5: begin
                add_text("/mcp/", 0);
                add_segments(0);
                add_byte(CH_SLASH);
            end
            6: begin
                add_text("/mcp/", 0);
                add_segments(1);
            end
            7: begin
                add_text("/mcp/", 0);
                add_segments(0);
                add_text("//", 0);
            end
            8: add_text("/mcpx", 0);
            9: add_text("/MCP", 0);
            10: add_text("/mc", 0);
            default: repeat ($urandom_range(0, 4)) add_byte(pick_safe());
        endcase
    endfunction

    function automatic void add_header();
        case ($urandom_range(13))
            0: add_text("host: h", 1);
            1, 2: begin
                add_text("content-length:", 1);
                add_lead();
                add_text("12", 0);
            end
            3, 4: begin
                add_text("transfer-encoding:", 1);
                add_lead();
                add_text("chunked", 1);
            end
            5: begin
                add_text("transfer-encoding:", 1);
                add_lead();
                add_text("identity", 1);
            end
            6: begin
                add_text("transfer-encoding:", 1);
                add_lead();
                case ($urandom_range(3))
                    0: add_text("gzip", 0);
                    1: add_text("chunke", 0);
                    2: add_text("chunkedx", 0);
                    default: add_text("identit", 0);
                endcase
            end
            7: begin
                if ($urandom_range(1) == 1) add_text("content-lengt: 1", 1);
                else add_text("content-lengthx: 1", 1);
            end
            8: begin
                if ($urandom_range(1) == 1) add_text("transfer-encodin: chunked", 1);
                else add_text("transfer-encodingx: chunked", 1);
            end
            9: add_text("no colon here", 1);
            10: add_text(": x", 0);
            11: begin
                add_text("transfer-encoding: identity", 1);
                add_byte(CH_CR);
            end
            12: repeat ($urandom_range(1, 8)) add_byte(8'($urandom_range(255)));
            default: add_text("transfer-encoding:", 1);
        endcase
    endfunction

    function automatic void build_request();
        stream_q.delete();
        case ($urandom_range(4))
            0, 1: add_text("GET", 0);
            2: add_text("POST", 0);
            3: add_text("OPTIONS", 0);
            default: repeat ($urandom_range(0, 3)) add_byte(8'h41 + 8'($urandom_range(25)));
        endcase
        if ($urandom_range(24) != 0) add_byte(CH_SP);
        add_target();
        if ($urandom_range(3) == 0) begin
            add_byte(CH_QUEST);
            repeat ($urandom_range(0, 5)) add_byte(pick_safe());
        end
        if ($urandom_range(24) != 0) begin
            add_byte(CH_SP);
            add_text("HTTP/1.1", 0);
        end
        case ($urandom_range(15))
            0: begin
                add_byte(CH_LF);
                add_text("x", 0);
                add_crlf();
            end
            1: begin
                add_byte(CH_CR);
                add_text("x", 0);
                add_crlf();
            end
            2: begin
                repeat ($urandom_range(1, 6)) add_byte(pick_safe());
                return;
            end
            default: add_crlf();
        endcase
        repeat ($urandom_range(0, 4)) begin
            add_header();
            if ($urandom_range(4) == 0) add_byte(CH_LF);
            else add_crlf();
        end
        case ($urandom_range(7))
            0: add_byte(CH_LF);
            1: ;
            default: add_crlf();
        endcase
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void build_noise();
        stream_q.delete();
        repeat ($urandom_range(1, 12)) add_byte(8'($urandom_range(255)));
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit first);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            item_if.valid <= 1'b0;
            @(posedge clk);
        end
        item_if.valid           <= 1'b1;
        item_if.data_byte       <= b;
        item_if.first_of_stream <= first;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
        sb.note_byte(b, first);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == 0);
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_if.valid      <= 1'b1;
        cfg_if.byte_limit <= value;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        cfg_if.valid <= 1'b0;
        sb.set_limit(value);
    endtask

    task automatic run_directed();
        stream_q.delete();
        add_text(" /mcp/% ", 0);
        add_crlf();
        send_stream();
        stream_q.delete();
        add_text(" /mcp ", 0);
        add_crlf();
        add_crlf();
        send_stream();
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
    endtask

    task automatic run_random(input int count);
        int stop_at;
        int keep;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            if ($urandom_range(99) < 15) build_noise();
            else build_request();
            if ($urandom_range(9) == 0) begin
                keep = $urandom_range(1, stream_q.size());
                while (stream_q.size() > keep) stream_q.delete(stream_q.size() - 1);
            end
            send_stream();
        end
    endtask

    initial begin
        tx_idle_pct    = 32;
        rx_idle_pct    = 53;
        stall_requests = 0;
        items_sent     = 0;
        rst_n                   <= 1'b0;
        item_if.valid           <= 1'b0;
        item_if.data_byte       <= '0;
        item_if.first_of_stream <= 1'b0;
        cfg_if.valid            <= 1'b0;
        cfg_if.byte_limit       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        wait_drained();
        write_limit(15'd40);
        run_random(350);
        wait_drained();
        write_limit(15'd1);
        run_random(200);
        wait_drained();

        tx_idle_pct = 53;
        rx_idle_pct = 32;
        write_limit(15'd0);
        run_random(150);
        wait_drained();
        write_limit(15'd32767);
        stall_requests++;
        run_random(350);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_limit(15'($urandom_range(2, 200)));
        stall_requests++;
        run_random(400);
        wait_drained();

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
